// ===== hdl/pzpc_pkg.sv =====
`timescale 1ns / 1ps
package pzpc_pkg;
    localparam int MaxVertices = 32;
    localparam int IdxW = $clog2(MaxVertices);
    localparam int CntW = 6;
    localparam int LatW = 31;
    localparam int LonW = 32;
    localparam int DxW = LonW + 1;
    localparam int DyW = LatW + 1;
    localparam int ProdW = DxW + DyW;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIFF,
        S_MUL,
        S_EVAL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [IdxW-1:0]   rd_addr;
    } t_rd_req;
endpackage

// ===== hdl/pzpc_vertex_ram.sv =====
`timescale 1ns / 1ps
module pzpc_vertex_ram #(
    parameter int Depth = 32,
    parameter int Width = 63
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr_a,
    input  logic [$clog2(Depth)-1:0] i_raddr_b,
    output logic [Width-1:0]         o_rdata_a,
    output logic [Width-1:0]         o_rdata_b
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

// ===== hdl/pzpc_edge_unit.sv =====
`timescale 1ns / 1ps
module pzpc_edge_unit
    import pzpc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_mul_en,
    input  logic signed [LonW-1:0] i_xi,
    input  logic signed [LatW-1:0] i_yi,
    input  logic signed [LonW-1:0] i_xj,
    input  logic signed [LatW-1:0] i_yj,
    input  logic signed [LonW-1:0] i_cx,
    input  logic signed [LatW-1:0] i_cy,
    input  logic signed [LonW-1:0] i_fx,
    input  logic signed [LatW-1:0] i_fy,
    output logic                   o_tog_c,
    output logic                   o_tog_f,
    output logic                   o_meet
);
    // differences registered in DIFF, products registered in MUL
    logic signed [DyW-1:0] r_d, r_pyc, r_pyf, r_aby, r_acy;
    logic signed [DxW-1:0] r_ex, r_pxc, r_pxf, r_abx, r_acx;
    logic                  r_spc, r_spf;
    logic signed [ProdW-1:0] r_lc, r_rc, r_lf, r_rf, r_dp, r_dq, r_tp, r_tq, r_up, r_uq;
    logic r_spc2, r_spf2, r_dpos;
    logic signed [DxW-1:0] w_cdx;

    assign w_cdx = DxW'(i_xj) - DxW'(i_xi);

    always_ff @(posedge i_clk) begin
        // DIFF stage
        r_d   <= DyW'(i_yj) - DyW'(i_yi);
        r_ex  <= w_cdx;
        r_pxc <= DxW'(i_cx) - DxW'(i_xi);
        r_pxf <= DxW'(i_fx) - DxW'(i_xi);
        r_pyc <= DyW'(i_cy) - DyW'(i_yi);
        r_pyf <= DyW'(i_fy) - DyW'(i_yi);
        r_spc <= (i_yi > i_cy) != (i_yj > i_cy);
        r_spf <= (i_yi > i_fy) != (i_yj > i_fy);
        r_abx <= DxW'(i_fx) - DxW'(i_cx);
        r_aby <= DyW'(i_fy) - DyW'(i_cy);
        r_acx <= DxW'(i_xi) - DxW'(i_cx);
        r_acy <= DyW'(i_yi) - DyW'(i_cy);
        if (i_mul_en) begin
            r_lc <= ProdW'(r_pxc) * ProdW'(r_d);
            r_rc <= ProdW'(r_ex) * ProdW'(r_pyc);
            r_lf <= ProdW'(r_pxf) * ProdW'(r_d);
            r_rf <= ProdW'(r_ex) * ProdW'(r_pyf);
            r_dp <= ProdW'(r_abx) * ProdW'(r_d);
            r_dq <= ProdW'(r_aby) * ProdW'(r_ex);
            r_tp <= ProdW'(r_acx) * ProdW'(r_d);
            r_tq <= ProdW'(r_acy) * ProdW'(r_ex);
            r_up <= ProdW'(r_acx) * ProdW'(r_aby);
            r_uq <= ProdW'(r_acy) * ProdW'(r_abx);
            r_spc2 <= r_spc;
            r_spf2 <= r_spf;
            r_dpos <= r_d > 0;
        end
    end

    logic signed [ProdW:0] w_den, w_t, w_u;
    logic                  w_tok, w_uok;
    always_comb begin
        w_den = (ProdW+1)'(r_dp) - (ProdW+1)'(r_dq);
        w_t   = (ProdW+1)'(r_tp) - (ProdW+1)'(r_tq);
        w_u   = (ProdW+1)'(r_up) - (ProdW+1)'(r_uq);
        w_tok = (w_t == 0) || ((w_t > 0) == (w_den > 0) &&
                ((w_den > 0) ? (w_t <= w_den) : (w_t >= w_den)));
        w_uok = (w_u == 0) || ((w_u > 0) == (w_den > 0) &&
                ((w_den > 0) ? (w_u <= w_den) : (w_u >= w_den)));
        o_meet  = (w_den != 0) && w_tok && w_uok;
        o_tog_c = r_spc2 && (r_dpos ? (r_lc < r_rc) : (r_lc > r_rc));
        o_tog_f = r_spf2 && (r_dpos ? (r_lf < r_rf) : (r_lf > r_rf));
    end
endmodule

// ===== hdl/polygon_zone_path_check.sv =====
`timescale 1ns / 1ps
// Geofence check of a path against a polygon of up to 32 vertices.
// Input: start with op; busy high means no new transaction is taken.
// A load transaction (op 0) writes one vertex into the vertex RAM and gives
// no result; loads can follow each other every cycle.
// A query transaction (op 1) gives one result on o_in_zone, o_end_inside and
// o_path_touch, marked by o_done for one cycle.
// A query walks each edge through the states READ, DIFF, MUL and EVAL,
// which follow the registered dual-read vertex RAM and the two-stage
// difference/multiply path, and ends in DONE. Fewer than three vertices
// answers with all flags low. A new transaction is taken in the cycle
// o_done is high, so a query is not taken until the last one is through.
// i_vertex_count_we writes the vertex count; use it only while idle.
// Synchronous active-low reset clears the count and the sequencer; the RAM
// holds no reset value and each slot must be loaded before it is queried.
// The receiver cannot stall: o_done lasts one cycle.
module polygon_zone_path_check
    import pzpc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_vertex_count_we,
    input  logic [CntW-1:0]        i_vertex_count,
    input  logic                   i_op,
    input  logic [4:0]             i_vertex_index,
    input  logic signed [LatW-1:0] i_vertex_lat,
    input  logic signed [LonW-1:0] i_vertex_lon,
    input  logic signed [LatW-1:0] i_cur_lat,
    input  logic signed [LonW-1:0] i_cur_lon,
    input  logic signed [LatW-1:0] i_fut_lat,
    input  logic signed [LonW-1:0] i_fut_lon,
    output logic                   o_done,
    output logic                   o_in_zone,
    output logic                   o_end_inside,
    output logic                   o_path_touch
);
    t_state r_state, n_state;
    logic [CntW-1:0] r_count;
    logic [CntW-1:0] r_n;
    logic [IdxW-1:0] r_i, n_i;
    logic signed [LatW-1:0] r_cy, r_fy;
    logic signed [LonW-1:0] r_cx, r_fx;
    logic r_a, r_b, r_c, n_a, n_b, n_c;
    logic r_done, n_done;
    logic w_acc, w_we, w_mul;
    t_rd_req w_rd;
    logic [LatW+LonW-1:0] w_ra, w_rb;
    logic w_tc, w_tf, w_meet;
    logic [IdxW-1:0] w_j;

    assign w_acc = start && !busy;
    assign w_we  = w_acc && (i_op == OP_LOAD);
    assign busy  = (r_state != S_IDLE);
    assign w_j   = (r_i == '0) ? IdxW'(r_n - 1'b1) : r_i - 1'b1;
    assign w_rd.rd_addr = r_i;
    assign w_mul = (r_state == S_MUL);

    pzpc_vertex_ram #(.Depth(MaxVertices), .Width(LatW + LonW)) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (i_vertex_index[IdxW-1:0]),
        .i_wdata   ({i_vertex_lat, i_vertex_lon}),
        .i_raddr_a (w_rd.rd_addr),
        .i_raddr_b (w_j),
        .o_rdata_a (w_ra),
        .o_rdata_b (w_rb)
    );

    // edge from vertex j to vertex i; segment test uses the same edge
    pzpc_edge_unit u_edge (
        .i_clk   (i_clk),
        .i_mul_en(w_mul),
        .i_xi    (w_ra[LonW-1:0]),
        .i_yi    (w_ra[LatW+LonW-1:LonW]),
        .i_xj    (w_rb[LonW-1:0]),
        .i_yj    (w_rb[LatW+LonW-1:LonW]),
        .i_cx    (r_cx), .i_cy(r_cy), .i_fx(r_fx), .i_fy(r_fy),
        .o_tog_c (w_tc),
        .o_tog_f (w_tf),
        .o_meet  (w_meet)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (i_vertex_count_we) begin
                r_count <= i_vertex_count;
            end
        end
        r_i <= n_i;
        r_a <= n_a;
        r_b <= n_b;
        r_c <= n_c;
        if (w_acc) begin
            r_cy <= i_cur_lat;
            r_cx <= i_cur_lon;
            r_fy <= i_fut_lat;
            r_fx <= i_fut_lon;
            r_n  <= (r_count > CntW'(MaxVertices)) ? CntW'(MaxVertices) : r_count;
        end
    end

    always_comb begin
        n_state = r_state;
        n_i = r_i;
        n_a = r_a;
        n_b = r_b;
        n_c = r_c;
        n_done = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_acc && i_op == OP_QUERY) begin
                    n_i = '0;
                    n_a = 1'b0;
                    n_b = 1'b0;
                    n_c = 1'b0;
                    n_state = (r_count < CntW'(3)) ? S_DONE : S_READ;
                end
            end
            S_READ: n_state = S_DIFF;
            S_DIFF: n_state = S_MUL;
            S_MUL:  n_state = S_EVAL;
            S_EVAL: begin
                n_a = r_a ^ w_tc;
                n_b = r_b ^ w_tf;
                n_c = r_c | w_meet;
                if (CntW'(r_i) + 1'b1 == r_n) begin
                    n_state = S_DONE;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                n_done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_done       = r_done;
    assign o_in_zone    = r_a;
    assign o_end_inside = r_b;
    assign o_path_touch = r_a | r_b | r_c;

`ifndef SYNTHESIS
    a_done_after_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> o_done) else $error("done strobe missing");
    a_done_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held too long");
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> (CntW'(r_i) < r_n)) else $error("edge index overrun");
`endif
endmodule

// ===== tb/polygon_zone_path_check_tb.sv =====
`timescale 1ns / 1ps
module polygon_zone_path_check_tb;
    import pzpc_pkg::*;

    localparam int WatchdogLimit = 20000;

    typedef struct {
        logic                   op;
        logic [4:0]             idx;
        logic signed [LatW-1:0] vlat;
        logic signed [LonW-1:0] vlon;
        logic signed [LatW-1:0] clat;
        logic signed [LonW-1:0] clon;
        logic signed [LatW-1:0] flat;
        logic signed [LonW-1:0] flon;
    } t_txn;

    typedef struct {
        logic in_zone;
        logic end_in;
        logic touch;
    } t_flags;

    // directed row: transaction plus optional typed-in answer
    typedef struct {
        t_txn   txn;
        logic   has_flags;
        t_flags flags;
    } t_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic                   i_vertex_count_we;
    logic [CntW-1:0]        i_vertex_count;
    logic                   i_op;
    logic [4:0]             i_vertex_index;
    logic signed [LatW-1:0] i_vertex_lat;
    logic signed [LonW-1:0] i_vertex_lon;
    logic signed [LatW-1:0] i_cur_lat;
    logic signed [LonW-1:0] i_cur_lon;
    logic signed [LatW-1:0] i_fut_lat;
    logic signed [LonW-1:0] i_fut_lon;
    logic                   o_done;
    logic                   o_in_zone;
    logic                   o_end_inside;
    logic                   o_path_touch;

    polygon_zone_path_check dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_vertex_count_we(i_vertex_count_we), .i_vertex_count(i_vertex_count),
        .i_op(i_op), .i_vertex_index(i_vertex_index),
        .i_vertex_lat(i_vertex_lat), .i_vertex_lon(i_vertex_lon),
        .i_cur_lat(i_cur_lat), .i_cur_lon(i_cur_lon),
        .i_fut_lat(i_fut_lat), .i_fut_lon(i_fut_lon),
        .o_done(o_done), .o_in_zone(o_in_zone),
        .o_end_inside(o_end_inside), .o_path_touch(o_path_touch)
    );

    // model copy of the vertex store and count
    longint  poly_lat [MaxVertices];
    longint  poly_lon [MaxVertices];
    int      poly_n;
    t_flags  pending_flags[$];
    int      errors = 0;
    int      idle_cycles = 0;
    int      idle_pct = 26;

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    function automatic logic point_inside(longint px, longint py, int n);
        logic   in_poly;
        int     j;
        longint yi, yj, xi, xj, d, lhs, rhs;
        in_poly = 1'b0;
        j = n - 1;
        for (int i = 0; i < n; i++) begin
            yi = poly_lat[i]; yj = poly_lat[j];
            xi = poly_lon[i]; xj = poly_lon[j];
            if ((yi > py) != (yj > py)) begin
                d = yj - yi;
                lhs = (px - xi) * d;
                rhs = (xj - xi) * (py - yi);
                if ((d > 0) ? (lhs < rhs) : (lhs > rhs)) in_poly = ~in_poly;
            end
            j = i;
        end
        return in_poly;
    endfunction

    // cross product ax*by - ay*bx; products fit in 64 bits, difference in 66
    function automatic logic signed [65:0] cross_prod(longint ax, longint ay,
                                                      longint bx, longint by);
        logic signed [65:0] p, q;
        p = ax * by;
        q = ay * bx;
        return p - q;
    endfunction

    function automatic logic in_unit(logic signed [65:0] num, logic signed [65:0] den);
        if (num == 0) return 1'b1;
        if ((num < 0) != (den < 0)) return 1'b0;
        return (num < 0) ? (num >= den) : (num <= den);
    endfunction

    function automatic logic segments_meet(longint ax, longint ay, longint bx, longint by,
                                           longint cx, longint cy, longint dx, longint dy);
        logic signed [65:0] den;
        den = cross_prod(bx - ax, by - ay, dx - cx, dy - cy);
        if (den == 0) return 1'b0;
        return in_unit(cross_prod(cx - ax, cy - ay, dx - cx, dy - cy), den) &&
               in_unit(cross_prod(cx - ax, cy - ay, bx - ax, by - ay), den);
    endfunction

    function automatic t_flags zone_flags(t_txn t);
        t_flags r;
        int     n;
        longint cx, cy, fx, fy;
        n = (poly_n > MaxVertices) ? MaxVertices : poly_n;
        r = '{1'b0, 1'b0, 1'b0};
        if (n < 3) return r;
        cy = t.clat; cx = t.clon; fy = t.flat; fx = t.flon;
        r.in_zone = point_inside(cx, cy, n);
        r.end_in  = point_inside(fx, fy, n);
        r.touch   = r.in_zone | r.end_in;
        for (int i = 0; i < n && !r.touch; i++) begin
            r.touch = segments_meet(cx, cy, fx, fy, poly_lon[i], poly_lat[i],
                                    poly_lon[(i + 1) % n], poly_lat[(i + 1) % n]);
        end
        return r;
    endfunction

    function automatic void apply_txn(t_txn t);
        if (t.op == OP_LOAD) begin
            poly_lat[t.idx] = t.vlat;
            poly_lon[t.idx] = t.vlon;
        end else begin
            pending_flags.push_back(zone_flags(t));
        end
    endfunction

    function automatic t_txn rand_txn(logic op, logic [4:0] idx, logic wide);
        t_txn t;
        t.op = op;
        t.idx = idx;
        if (wide) begin
            t.vlat = LatW'($urandom_range(1800000000) - 900000000);
            t.vlon = $urandom_range(2000000000) + $urandom_range(1600000000) - 1800000000;
            t.clat = LatW'($urandom_range(1800000000) - 900000000);
            t.clon = $urandom_range(2000000000) + $urandom_range(1600000000) - 1800000000;
            t.flat = LatW'($urandom_range(1800000000) - 900000000);
            t.flon = $urandom_range(2000000000) + $urandom_range(1600000000) - 1800000000;
        end else begin
            // narrow window so queries land near the polygon
            t.vlat = LatW'($urandom_range(2000) - 1000);
            t.vlon = $urandom_range(2000) - 1000;
            t.clat = LatW'($urandom_range(2400) - 1200);
            t.clon = $urandom_range(2400) - 1200;
            t.flat = LatW'($urandom_range(2400) - 1200);
            t.flon = $urandom_range(2400) - 1200;
        end
        return t;
    endfunction

    // start stays high after acceptance until the next idle cycle or drain
    task automatic send_txn(t_txn t);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_op <= t.op;
        i_vertex_index <= t.idx;
        i_vertex_lat <= t.vlat;
        i_vertex_lon <= t.vlon;
        i_cur_lat <= t.clat;
        i_cur_lon <= t.clon;
        i_fut_lat <= t.flat;
        i_fut_lon <= t.flon;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        apply_txn(t);
    endtask

    // wait for all results, then let a trailing load-free window pass
    task automatic drain();
        start <= 1'b0;
        while (pending_flags.size() != 0) @(posedge i_clk);
        repeat (4 * MaxVertices + 8) @(posedge i_clk);
    endtask

    task automatic write_count(int n);
        i_vertex_count_we <= 1'b1;
        i_vertex_count <= CntW'(n);
        @(posedge i_clk);
        i_vertex_count_we <= 1'b0;
        poly_n = n;
    endtask

    // check results; sample just after the edge that accepts them
    always @(posedge i_clk) begin
        t_flags exp_f;
        if (i_rst_n && o_done) begin
            idle_cycles <= 0;
            if (pending_flags.size() == 0) begin
                $display("%0t: unexpected result %b%b%b", $time,
                         o_in_zone, o_end_inside, o_path_touch);
                errors++;
            end else begin
                exp_f = pending_flags.pop_front();
                if (o_in_zone !== exp_f.in_zone) begin
                    $display("%0t: in_zone exp %b got %b", $time, exp_f.in_zone, o_in_zone);
                    errors++;
                end
                if (o_end_inside !== exp_f.end_in) begin
                    $display("%0t: end_inside exp %b got %b", $time,
                             exp_f.end_in, o_end_inside);
                    errors++;
                end
                if (o_path_touch !== exp_f.touch) begin
                    $display("%0t: path_touch exp %b got %b", $time,
                             exp_f.touch, o_path_touch);
                    errors++;
                end
            end
        end else if (start && !busy) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WatchdogLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    t_row rows[$];

    task automatic add_row(t_txn t, logic has, t_flags f);
        t_row r;
        r.txn = t; r.has_flags = has; r.flags = f;
        rows.push_back(r);
    endtask

    function automatic t_txn mk(logic op, logic [4:0] idx, longint vla, longint vlo,
                                longint cla, longint clo, longint fla, longint flo);
        t_txn t;
        t.op = op; t.idx = idx; t.vlat = LatW'(vla); t.vlon = LonW'(vlo);
        t.clat = LatW'(cla); t.clon = LonW'(clo); t.flat = LatW'(fla); t.flon = LonW'(flo);
        return t;
    endfunction

    initial begin
        t_txn   t;
        int     n;
        int     items;
        t_flags zero_f;
        zero_f = '{1'b0, 1'b0, 1'b0};
        i_rst_n = 1'b0;
        start = 1'b0;
        i_vertex_count_we = 1'b0;
        i_vertex_count = '0;
        i_op = OP_LOAD;
        i_vertex_index = '0;
        i_vertex_lat = '0; i_vertex_lon = '0;
        i_cur_lat = '0; i_cur_lon = '0; i_fut_lat = '0; i_fut_lon = '0;
        poly_n = 0;
        foreach (poly_lat[i]) begin
            poly_lat[i] = 0; poly_lon[i] = 0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: count 0 answers all low, square at full-range extremes
        add_row(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0), 1'b1, zero_f);
        add_row(mk(OP_LOAD, 0, -900000000, -1800000000, 5, 5, 5, 5), 1'b0, zero_f);
        add_row(mk(OP_LOAD, 1, -900000000, 1800000000, 0, 0, 0, 0), 1'b0, zero_f);
        add_row(mk(OP_LOAD, 2, 900000000, 1800000000, 0, 0, 0, 0), 1'b0, zero_f);
        add_row(mk(OP_LOAD, 3, 900000000, -1800000000, 0, 0, 0, 0), 1'b0, zero_f);
        add_row(mk(OP_LOAD, 31, 100, -100, 0, 0, 0, 0), 1'b0, zero_f);
        // still count 0: too few vertices, even with an inside point
        add_row(mk(OP_QUERY, 0, 7, 7, 0, 0, 1, 1), 1'b1, zero_f);
        foreach (rows[i]) begin
            send_txn(rows[i].txn);
            if (rows[i].has_flags && rows[i].txn.op == OP_QUERY)
                pending_flags[pending_flags.size() - 1] = rows[i].flags;
        end
        drain();
        rows.delete();

        write_count(2);
        add_row(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0), 1'b1, zero_f);
        foreach (rows[i]) send_txn(rows[i].txn);
        drain();
        rows.delete();

        write_count(4);
        add_row(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0), 1'b1, '{1'b1, 1'b1, 1'b1});
        add_row(mk(OP_QUERY, 0, 0, 0, 899999999, 1799999999, -899999999, -1799999999),
                1'b1, '{1'b1, 1'b1, 1'b1});
        // path along the boundary edge (parallel case) and through a corner
        add_row(mk(OP_QUERY, 0, 0, 0, -900000000, -1800000000, -900000000, 1800000000),
                1'b0, zero_f);
        add_row(mk(OP_QUERY, 0, 0, 0, 0, 0, 900000000, 1800000000), 1'b0, zero_f);
        add_row(mk(OP_QUERY, 0, 0, 0, 0, -2147483648, 0, 2147483647), 1'b0, zero_f);
        add_row(mk(OP_QUERY, 0, -1, -1, -1073741824, -2147483648, 1073741823, 2147483647),
                1'b0, zero_f);
        add_row(mk(OP_QUERY, 0, 0, 0, 1073741823, 2147483647, 1073741823, -2147483648),
                1'b1, zero_f);
        add_row(mk(OP_LOAD, 4, 0, 0, 0, 0, 0, 0), 1'b0, zero_f);
        foreach (rows[i]) begin
            send_txn(rows[i].txn);
            if (rows[i].has_flags) pending_flags[pending_flags.size() - 1] = rows[i].flags;
        end
        drain();
        rows.delete();

        // random phases: load every slot in use, then mostly queries
        items = 0;
        while (items < 700) begin
            case ($urandom_range(5))
                0: n = 3;
                1: n = 32;
                2: n = 63;
                default: n = $urandom_range(3, 12);
            endcase
            // phases that start with items between 300 and 380 run with no idling
            idle_pct = (items > 300 && items < 380) ? 0 : 26;
            for (int i = 0; i < ((n > MaxVertices) ? MaxVertices : n); i++) begin
                send_txn(rand_txn(OP_LOAD, 5'(i), $urandom_range(9) == 0));
                items++;
            end
            drain();
            write_count(n);
            for (int q = 0; q < 25; q++) begin
                if ($urandom_range(9) == 0) begin
                    // a reload of a slot in use keeps every read slot defined
                    t = rand_txn(OP_LOAD, 5'($urandom_range(((n > MaxVertices) ?
                                 MaxVertices : n) - 1)), 1'b0);
                end else begin
                    t = rand_txn(OP_QUERY, 5'($urandom), $urandom_range(7) == 0);
                end
                send_txn(t);
                items++;
            end
            // hold until every pending result is back
            drain();
        end
        drain();
        if (errors == 0 && pending_flags.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/pzpc_pkg.sv
hdl/pzpc_vertex_ram.sv
hdl/pzpc_edge_unit.sv
hdl/polygon_zone_path_check.sv
tb/polygon_zone_path_check_tb.sv
